// ===== src/srq_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// srq_pkg - shared types and codes for the sorted run queue
// Request and response payloads, the stored entry and the per-cycle control
// broadcast to the row of queue cells.
// ---------------------------------------------------------------------------
package srq_pkg;

   localparam int LOAD_W   = 25;
   localparam int WEIGHT_W = 17;
   localparam int KEY_W    = 64;
   localparam int TAG_W    = 16;
   localparam int RCNT_W   = 9;

   // operation codes on the request
   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_PICK   = 1'b1
   } srq_kind_type;

   // result codes
   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_DROPPED  = 2'd1,
      ST_PICKED   = 2'd2,
      ST_EMPTY    = 2'd3
   } srq_status_type;

   typedef struct packed {
      srq_kind_type        kind;
      logic [TAG_W-1:0]    task_tag;
      logic [KEY_W-1:0]    task_vruntime;
      logic [WEIGHT_W-1:0] task_weight;
   } srq_req_type;

   typedef struct packed {
      srq_status_type      status;
      logic [TAG_W-1:0]    out_tag;
      logic [KEY_W-1:0]    out_vruntime;
      logic [WEIGHT_W-1:0] out_weight;
      logic [RCNT_W-1:0]   ready_count;
      logic [LOAD_W-1:0]   load_total;
      logic [KEY_W-1:0]    min_key;
      logic [63:0]         pick_total;
   } srq_rsp_type;

   // one stored task
   typedef struct packed {
      logic [KEY_W-1:0]    key;
      logic [TAG_W-1:0]    tag;
      logic [WEIGHT_W-1:0] weight;
   } srq_entry_type;

   // control broadcast to every cell
   typedef struct packed {
      logic          do_insert;
      logic          do_pick;
      srq_entry_type new_entry;
   } srq_ctrl_type;

endpackage

// ===== src/srq_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// srq_cell - one slot of the sorted queue
// Holds one entry. On insert it keeps its entry, takes the new one or takes
// its left neighbour's; on pick it takes its right neighbour's.
// ---------------------------------------------------------------------------
module srq_cell #(
   parameter int CNT_W      = 9,
   parameter int CELL_INDEX = 0
) (
   input  logic                  clock,
   input  srq_pkg::srq_ctrl_type ctrl,
   input  logic [CNT_W-1:0]      count,
   input  srq_pkg::srq_entry_type left_entry,
   input  logic                  left_place,
   input  srq_pkg::srq_entry_type right_entry,
   output srq_pkg::srq_entry_type entry,
   output logic                  place
);
   import srq_pkg::*;

   localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(CELL_INDEX);

   srq_entry_type entry_ff;
   srq_entry_type entry_in;
   logic          occupied;

   // new entry belongs here or further left: empty slot, or stored key >= new
   assign occupied = MY_INDEX < count;
   assign place    = !occupied || !(entry_ff.key < ctrl.new_entry.key);

   // slot update
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.do_insert) begin
         if (place && !left_place) begin
            entry_in = ctrl.new_entry;
         end else if (place) begin
            entry_in = left_entry;
         end
      end else if (ctrl.do_pick) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== src/sorted_run_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_run_queue - run queue sorted by virtual runtime
// Channel   Ports                      Direction  Transfer
// request   start, busy, req_item      in         start high, busy low
// response  rsp_valid, rsp_item        out        one-cycle strobe
//
// One item per cycle while busy is low: every accepted item updates the row
// of cells in the cycle it is taken, and its response is strobed in the
// following cycle. The rate is set by the per-cell key compare, done in all
// cells at once. Reset is synchronous; busy is set by reset and clears once
// reset is released. The receiver cannot stall, so no response is held back.
// ---------------------------------------------------------------------------
module sorted_run_queue #(
   parameter int QUEUE_DEPTH = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  srq_pkg::srq_req_type req_item,
   output logic                 rsp_valid,
   output srq_pkg::srq_rsp_type rsp_item
);
   import srq_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [LOAD_W-1:0] load_ff, load_in;
   logic [KEY_W-1:0]  lowest_ff, lowest_in;
   logic [63:0]       picks_ff, picks_in;
   logic              busy_ff;
   logic              rsp_valid_ff;
   srq_rsp_type       rsp_ff, rsp_in;

   logic              accept;
   logic              full, empty;
   srq_ctrl_type      ctrl;
   logic [WEIGHT_W-1:0] ins_eff, head_eff;
   logic [LOAD_W:0]   load_sum;
   logic [CNT_W+RCNT_W-1:0] count_wide;

   srq_entry_type cell_entry [QUEUE_DEPTH];
   logic          cell_place [QUEUE_DEPTH];

   // request decode
   assign accept = start && !busy_ff;
   assign full   = count_ff == FULL_CNT;
   assign empty  = count_ff == '0;

   always_comb begin
      ctrl.do_insert           = accept && (req_item.kind == KIND_INSERT) && !full;
      ctrl.do_pick             = accept && (req_item.kind == KIND_PICK) && !empty;
      ctrl.new_entry.key       = req_item.task_vruntime;
      ctrl.new_entry.tag       = req_item.task_tag;
      ctrl.new_entry.weight    = req_item.task_weight;
   end

   // row of cells
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      srq_entry_type left_e, right_e;
      logic          left_p;
      if (i == 0) begin : g_head
         assign left_e = cell_entry[i];
         assign left_p = 1'b0;
      end else begin : g_body
         assign left_e = cell_entry[i-1];
         assign left_p = cell_place[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_e = cell_entry[i];
      end else begin : g_mid
         assign right_e = cell_entry[i+1];
      end
      srq_cell #(
         .CNT_W      (CNT_W),
         .CELL_INDEX (i)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .count       (count_ff),
         .left_entry  (left_e),
         .left_place  (left_p),
         .right_entry (right_e),
         .entry       (cell_entry[i]),
         .place       (cell_place[i])
      );
   end

   // effective weights, zero counts as one
   assign ins_eff  = (req_item.task_weight == '0) ? WEIGHT_W'(1) : req_item.task_weight;
   assign head_eff = (cell_entry[0].weight == '0) ? WEIGHT_W'(1) : cell_entry[0].weight;
   assign load_sum = {1'b0, load_ff} + (LOAD_W+1)'(ins_eff);

   // queue totals
   always_comb begin
      count_in  = count_ff;
      load_in   = load_ff;
      lowest_in = lowest_ff;
      picks_in  = picks_ff;
      if (ctrl.do_insert) begin
         count_in = count_ff + CNT_ONE;
         load_in  = load_sum[LOAD_W] ? {LOAD_W{1'b1}} : load_sum[LOAD_W-1:0];
         if (empty || (req_item.task_vruntime < lowest_ff)) begin
            lowest_in = req_item.task_vruntime;
         end
      end else if (ctrl.do_pick) begin
         count_in  = count_ff - CNT_ONE;
         load_in   = (load_ff >= LOAD_W'(head_eff)) ? load_ff - LOAD_W'(head_eff) : '0;
         lowest_in = (count_ff > CNT_ONE) ? cell_entry[1].key : '0;
         picks_in  = picks_ff + 64'd1;
      end
   end

   // response build
   assign count_wide = {{RCNT_W{1'b0}}, count_in};

   always_comb begin
      rsp_in              = '0;
      rsp_in.ready_count  = count_wide[RCNT_W-1:0];
      rsp_in.load_total   = load_in;
      rsp_in.min_key      = lowest_in;
      rsp_in.pick_total   = picks_in;
      if (req_item.kind == KIND_INSERT) begin
         rsp_in.status = full ? ST_DROPPED : ST_INSERTED;
      end else if (empty) begin
         rsp_in.status = ST_EMPTY;
      end else begin
         rsp_in.status       = ST_PICKED;
         rsp_in.out_tag      = cell_entry[0].tag;
         rsp_in.out_vruntime = cell_entry[0].key;
         rsp_in.out_weight   = cell_entry[0].weight;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         load_ff      <= '0;
         lowest_ff    <= '0;
         picks_ff     <= '0;
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         load_ff      <= load_in;
         lowest_ff    <= lowest_in;
         picks_ff     <= picks_in;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= accept;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ===== src/srq_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// srq_checker - port-level checks for the sorted run queue
// Watches the request and response ports and checks result timing and the
// consistency of reported status against the queue totals.
// ---------------------------------------------------------------------------
module srq_checker #(
   parameter int QUEUE_DEPTH = 256
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input srq_pkg::srq_rsp_type rsp_item
);
   import srq_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W+RCNT_W-1:0] FULL_WIDE = (CNT_W+RCNT_W)'(QUEUE_DEPTH);

   // every transfer in gives exactly one response, next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("no response after accepted request");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_valid)
      else $error("response without request");

   // empty pick leaves nothing queued and returns zero fields
   a_empty_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status == ST_EMPTY) |->
         (rsp_item.ready_count == '0 && rsp_item.load_total == '0 &&
          rsp_item.out_tag == '0 && rsp_item.out_vruntime == '0))
      else $error("empty status with queue contents");

   // a dropped insert only happens at full occupancy
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status == ST_DROPPED) |->
         rsp_item.ready_count == FULL_WIDE[RCNT_W-1:0])
      else $error("insert dropped below full occupancy");

   // successful insert always leaves load non-zero and returns a zero weight field
   a_insert_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status == ST_INSERTED) |->
         (rsp_item.load_total != '0 && rsp_item.out_weight == '0))
      else $error("insert left no load");

endmodule

bind sorted_run_queue srq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_srq_checker (.*);

// ===== bench/sorted_run_queue_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_run_queue_tb - self-checking bench for the sorted run queue
// Drives insert and pick commands in random bursts and keeps its own sorted
// copy of the queue. Every strobed response is checked field by field
// against the oldest outstanding prediction. A short directed sequence
// covers empty picks, equal vruntimes and extreme values. The random part
// then mixes traffic, fills the queue past full and runs it back down.
// ---------------------------------------------------------------------------
module sorted_run_queue_tb;

   import srq_pkg::*;

   localparam int              QUEUE_DEPTH = 256;
   localparam int              WEIGHT_MAX  = 88761;
   localparam logic [LOAD_W-1:0] LOAD_LIMIT = '1;

   // Reference copy of the queue plus the list of responses still owed
   class run_queue_scoreboard;
      srq_entry_type     queued_tasks[$];
      srq_rsp_type       owed_results[$];
      logic [LOAD_W-1:0] load_sum;
      logic [KEY_W-1:0]  lowest_vruntime;
      logic [63:0]       picks_done;
      int unsigned       n_inserted, n_dropped, n_picked, n_empty;
      int unsigned       peak_occupancy, n_checked, n_mismatch, n_stray;

      function new();
         load_sum        = '0;
         lowest_vruntime = '0;
         picks_done      = '0;
         n_inserted      = 0;
         n_dropped       = 0;
         n_picked        = 0;
         n_empty         = 0;
         peak_occupancy  = 0;
         n_checked       = 0;
         n_mismatch      = 0;
         n_stray         = 0;
      endfunction

      function int unsigned pending();
         return owed_results.size();
      endfunction

      function int unsigned failures();
         return n_mismatch + n_stray + owed_results.size();
      endfunction

      // Apply one accepted command and queue the response it must produce
      function void note_transfer(srq_req_type req);
         srq_rsp_type       want;
         srq_entry_type     entry;
         int                pos;
         logic [LOAD_W:0]   load_next;
         logic [LOAD_W-1:0] eff_weight;
         want = '0;
         if (req.kind == KIND_INSERT) begin
            if (queued_tasks.size() >= QUEUE_DEPTH) begin
               want.status = ST_DROPPED;
               n_dropped++;
            end else begin
               // new task goes ahead of any entry with an equal vruntime
               pos = 0;
               while (pos < queued_tasks.size() &&
                      queued_tasks[pos].key < req.task_vruntime)
                  pos++;
               entry.key    = req.task_vruntime;
               entry.tag    = req.task_tag;
               entry.weight = req.task_weight;
               queued_tasks.insert(pos, entry);
               eff_weight = (req.task_weight == '0) ? LOAD_W'(1) : LOAD_W'(req.task_weight);
               load_next  = {1'b0, load_sum} + {1'b0, eff_weight};
               load_sum   = (load_next > LOAD_LIMIT) ? LOAD_LIMIT : load_next[LOAD_W-1:0];
               if (queued_tasks.size() == 1 || req.task_vruntime < lowest_vruntime)
                  lowest_vruntime = req.task_vruntime;
               want.status = ST_INSERTED;
               n_inserted++;
            end
         end else if (queued_tasks.size() == 0) begin
            want.status = ST_EMPTY;
            n_empty++;
         end else begin
            entry           = queued_tasks.pop_front();
            want.status     = ST_PICKED;
            want.out_tag      = entry.tag;
            want.out_vruntime = entry.key;
            want.out_weight   = entry.weight;
            eff_weight = (entry.weight == '0) ? LOAD_W'(1) : LOAD_W'(entry.weight);
            load_sum   = (load_sum >= eff_weight) ? load_sum - eff_weight : '0;
            lowest_vruntime = (queued_tasks.size() > 0) ? queued_tasks[0].key : '0;
            picks_done++;
            n_picked++;
         end
         if (queued_tasks.size() > peak_occupancy)
            peak_occupancy = queued_tasks.size();
         want.ready_count = RCNT_W'(queued_tasks.size());
         want.load_total  = load_sum;
         want.min_key     = lowest_vruntime;
         want.pick_total  = picks_done;
         owed_results.push_back(want);
      endfunction

      // Compare one strobed response with the oldest prediction
      function void check_result(srq_rsp_type got);
         srq_rsp_type want;
         string       diffs;
         if (owed_results.size() == 0) begin
            n_stray++;
            if (n_stray + n_mismatch <= 10)
               $display("ERROR: response with nothing outstanding, status %0d tag %h",
                        got.status, got.out_tag);
            return;
         end
         want = owed_results.pop_front();
         n_checked++;
         diffs = "";
         if (got.status !== want.status)
            diffs = {diffs, $sformatf(" status exp %0d got %0d", want.status, got.status)};
         if (got.out_tag !== want.out_tag)
            diffs = {diffs, $sformatf(" tag exp %h got %h", want.out_tag, got.out_tag)};
         if (got.out_vruntime !== want.out_vruntime)
            diffs = {diffs, $sformatf(" vruntime exp %h got %h",
                                      want.out_vruntime, got.out_vruntime)};
         if (got.out_weight !== want.out_weight)
            diffs = {diffs, $sformatf(" weight exp %0d got %0d",
                                      want.out_weight, got.out_weight)};
         if (got.ready_count !== want.ready_count)
            diffs = {diffs, $sformatf(" count exp %0d got %0d",
                                      want.ready_count, got.ready_count)};
         if (got.load_total !== want.load_total)
            diffs = {diffs, $sformatf(" load exp %0d got %0d",
                                      want.load_total, got.load_total)};
         if (got.min_key !== want.min_key)
            diffs = {diffs, $sformatf(" min exp %h got %h", want.min_key, got.min_key)};
         if (got.pick_total !== want.pick_total)
            diffs = {diffs, $sformatf(" picks exp %0d got %0d",
                                      want.pick_total, got.pick_total)};
         if (diffs != "") begin
            n_mismatch++;
            if (n_stray + n_mismatch <= 10)
               $display("MISMATCH on response %0d:%s", n_checked, diffs);
         end
      endfunction
   endclass

   logic        clock    = 1'b0;
   logic        reset    = 1'b1;
   logic        start    = 1'b0;
   srq_req_type req_item = '0;
   logic        busy;
   logic        rsp_valid;
   srq_rsp_type rsp_item;

   run_queue_scoreboard sb = new();
   int unsigned         burst_left = 0;

   sorted_run_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // 50 MHz clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Observe transfers and responses on the pre-edge values
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            sb.note_transfer(req_item);
         if (rsp_valid)
            sb.check_result(rsp_item);
      end
   end

   function automatic srq_req_type make_req(srq_kind_type kind, logic [TAG_W-1:0] tag,
                                            logic [KEY_W-1:0] key,
                                            logic [WEIGHT_W-1:0] weight);
      srq_req_type req;
      req.kind          = kind;
      req.task_tag      = tag;
      req.task_vruntime = key;
      req.task_weight   = weight;
      return req;
   endfunction

   // Keys lean on a small pool so that equal vruntimes are common
   function automatic logic [KEY_W-1:0] random_vruntime();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return KEY_W'($urandom_range(0, 15));
         4:          return '0;
         5:          return '1;
         6:          return {32'hFFFF_FFFF, 32'($urandom)};
         default:    return {32'($urandom), 32'($urandom)};
      endcase
   endfunction

   function automatic logic [WEIGHT_W-1:0] random_weight();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return WEIGHT_W'(WEIGHT_MAX);
         default: return WEIGHT_W'($urandom_range(0, WEIGHT_MAX));
      endcase
   endfunction

   // Pick commands still carry random payload as noise
   function automatic srq_req_type random_req(int unsigned insert_pct);
      srq_kind_type kind;
      kind = ($urandom_range(1, 100) <= insert_pct) ? KIND_INSERT : KIND_PICK;
      return make_req(kind, TAG_W'($urandom), random_vruntime(), random_weight());
   endfunction

   // Hold one command until it is taken
   task automatic drive_request(input srq_req_type req);
      start    <= 1'b1;
      req_item <= req;
      do @(posedge clock); while (busy);
   endtask

   // Bursts of back-to-back transfers separated by random idle gaps
   task automatic send(input srq_req_type req);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      drive_request(req);
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty pick, extremes, zero weight, ties and unsigned order
      send(make_req(KIND_PICK,   16'h0000, '0, '0));
      send(make_req(KIND_INSERT, 16'h0000, '0, '0));
      send(make_req(KIND_INSERT, 16'hFFFF, '1, WEIGHT_W'(WEIGHT_MAX)));
      send(make_req(KIND_INSERT, 16'h1234, 64'd100, 17'd1));
      send(make_req(KIND_INSERT, 16'hA5A5, 64'd100, 17'd2));
      repeat (4) send(make_req(KIND_PICK, '1, '1, '1));
      send(make_req(KIND_PICK,   16'h5A5A, 64'd7, 17'd7));
      // first insert into an empty queue sets the minimum even above zero
      send(make_req(KIND_INSERT, 16'h0050, 64'd50, 17'h10000));
      send(make_req(KIND_INSERT, 16'h0010, 64'd10, 17'h0FFFF));
      send(make_req(KIND_INSERT, 16'h0070, 64'd70, 17'd0));
      send(make_req(KIND_INSERT, 16'h8000, 64'h8000_0000_0000_0000, 17'd3));
      send(make_req(KIND_INSERT, 16'h7FFF, 64'h7FFF_FFFF_FFFF_FFFF, 17'd4));
      repeat (6) send(make_req(KIND_PICK, '0, '0, '0));

      // random mixed traffic, then a full pause
      repeat (60) send(random_req(65));
      wait_for_results();

      // fill well past full so that inserts are dropped
      repeat (QUEUE_DEPTH + 8) send(random_req(100));

      // run it back down with picks and refills
      repeat (90) send(random_req(40));

      wait_for_results();
      repeat (4) @(posedge clock);

      $display("Covered %0d inserts, %0d drops on a full queue, %0d picks, %0d empty picks.",
               sb.n_inserted, sb.n_dropped, sb.n_picked, sb.n_empty);
      $display("Peak occupancy %0d of %0d; %0d responses checked, %0d mismatched.",
               sb.peak_occupancy, QUEUE_DEPTH, sb.n_checked, sb.n_mismatch + sb.n_stray);
      if (sb.failures() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("Timeout with %0d responses outstanding", sb.pending());
      $display("TEST FAILED");
      $finish;
   end

endmodule
